>>> sv/rvx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared constants for the RV32I execute block: opcodes, function codes and
// memory size defaults.
// ----------------------------------------------------------------------------
package rvx_pkg;

  localparam int unsigned DataMemBytes = 4096;

  localparam logic [6:0] OpLui    = 7'h37;
  localparam logic [6:0] OpAuipc  = 7'h17;
  localparam logic [6:0] OpJal    = 7'h6F;
  localparam logic [6:0] OpJalr   = 7'h67;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpReg    = 7'h33;

  localparam logic [6:0] F7Zero = 7'h00;
  localparam logic [6:0] F7Alt  = 7'h20;

  localparam logic [2:0] F3Beq  = 3'd0;
  localparam logic [2:0] F3Bne  = 3'd1;
  localparam logic [2:0] F3Blt  = 3'd4;
  localparam logic [2:0] F3Bge  = 3'd5;
  localparam logic [2:0] F3Bltu = 3'd6;
  localparam logic [2:0] F3Bgeu = 3'd7;

  localparam logic [2:0] F3Lb  = 3'd0;
  localparam logic [2:0] F3Lh  = 3'd1;
  localparam logic [2:0] F3Lw  = 3'd2;
  localparam logic [2:0] F3Lbu = 3'd4;
  localparam logic [2:0] F3Lhu = 3'd5;

  localparam logic [2:0] F3Add  = 3'd0;
  localparam logic [2:0] F3Sll  = 3'd1;
  localparam logic [2:0] F3Slt  = 3'd2;
  localparam logic [2:0] F3Sltu = 3'd3;
  localparam logic [2:0] F3Xor  = 3'd4;
  localparam logic [2:0] F3Sr   = 3'd5;
  localparam logic [2:0] F3Or   = 3'd6;
  localparam logic [2:0] F3And  = 3'd7;

  localparam logic [1:0] SizeByte = 2'd0;
  localparam logic [1:0] SizeHalf = 2'd1;
  localparam logic [1:0] SizeWord = 2'd2;

endpackage

>>> sv/rvx_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_in_if
// Instruction channel: valid/ready handshake carrying one instruction word.
// ----------------------------------------------------------------------------
interface rvx_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink (input valid, input instruction_word, output ready);
endinterface

>>> sv/rvx_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_out_if
// Result channel: valid/ready handshake carrying one execution report.
// ----------------------------------------------------------------------------
interface rvx_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_address;
  logic [31:0] next_pc;
  logic        writes_register;
  logic [4:0]  dest_register;
  logic [31:0] dest_value;
  logic        did_store;
  logic [31:0] store_address;
  logic [31:0] store_value;
  logic [1:0]  store_size;
  logic        illegal;

  modport source (output valid, output instruction_address, output next_pc,
                  output writes_register, output dest_register, output dest_value,
                  output did_store, output store_address, output store_value,
                  output store_size, output illegal, input ready);
  modport sink (input valid, input instruction_address, input next_pc,
                input writes_register, input dest_register, input dest_value,
                input did_store, input store_address, input store_value,
                input store_size, input illegal, output ready);
endinterface

>>> sv/rv32i_integer_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32i_integer_execute
// RV32I execute block with a synchronous register file and byte-banked data
// memory.
// ----------------------------------------------------------------------------
// Pipeline: register file read at the transfer edge, then execute with data
//   memory access, then load alignment and writeback into the output register.
// Throughput: one instruction per cycle while the output is not stalled; all
//   hazards are covered by forwarding.
// Reset: clears the pipeline, register valid bits and start_pc; the pc takes
//   start_pc. Data memory is not cleared.
module rv32i_integer_execute
  import rvx_pkg::*;
#(
  parameter int unsigned DATA_MEM_BYTES = DataMemBytes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  rvx_in_if.sink      in_ch,
  rvx_out_if.source   out_ch
);

  // Memory geometry: four byte banks, one per address lane.
  localparam int unsigned AW   = $clog2(DATA_MEM_BYTES);
  localparam int unsigned ROWS = DATA_MEM_BYTES / 4;
  localparam int unsigned RW   = AW - 2;

  // Configuration
  logic [31:0] start_pc;
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pc <= '0;
    end else if (cfg_we) begin
      start_pc <= cfg_wdata;
    end
  end

  // Pipeline advances whenever the output register is free or being drained.
  logic advance;
  assign advance = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = advance;

  // Stage 1 (execute) registers
  logic        s1_valid;
  logic [31:0] s1_word;
  logic [31:0] pc;

  // Stage 2 (load align / writeback) registers
  logic        s2_valid;
  logic [31:0] s2_pc;
  logic [31:0] s2_next;
  logic        s2_wr;
  logic [4:0]  s2_rd;
  logic [31:0] s2_alu;
  logic        s2_load;
  logic [2:0]  s2_f3;
  logic [1:0]  s2_lane;
  logic        s2_st;
  logic [31:0] s2_saddr;
  logic [31:0] s2_sval;
  logic [1:0]  s2_ssize;
  logic        s2_ill;
  logic [31:0] s2_val;

  // Write committed at the edge where the stage-1 instruction read the file.
  logic        lw_valid;
  logic [4:0]  lw_rd;
  logic [31:0] lw_val;

  // ---------------------------------------------------------------------------
  // Register file: 32 entries, two registered read ports, valid bits for reset.
  // ---------------------------------------------------------------------------
  logic [31:0] rf [32];
  logic [31:0] rf_vld;
  logic [31:0] rd_a, rd_b;
  logic        rd_a_vld, rd_b_vld;
  logic        s2_commit;

  assign s2_commit = advance && s2_valid && s2_wr;

  always_ff @(posedge clk) begin
    if (s2_commit) begin
      rf[s2_rd] <= s2_val;
    end
    if (advance) begin
      rd_a <= rf[in_ch.instruction_word[19:15]];
      rd_b <= rf[in_ch.instruction_word[24:20]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld   <= '0;
      rd_a_vld <= 1'b0;
      rd_b_vld <= 1'b0;
      lw_valid <= 1'b0;
    end else if (advance) begin
      if (s2_valid && s2_wr) begin
        rf_vld[s2_rd] <= 1'b1;
      end
      rd_a_vld <= rf_vld[in_ch.instruction_word[19:15]];
      rd_b_vld <= rf_vld[in_ch.instruction_word[24:20]];
      lw_valid <= s2_valid && s2_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lw_rd  <= s2_rd;
      lw_val <= s2_val;
    end
  end

  // Operand forwarding: stage 2 first, then the write at the read edge.
  logic [4:0]  rs1, rs2;
  logic [31:0] a, b;
  assign rs1 = s1_word[19:15];
  assign rs2 = s1_word[24:20];

  always_comb begin
    if (rs1 == 5'd0) begin
      a = '0;
    end else if (s2_valid && s2_wr && s2_rd == rs1) begin
      a = s2_val;
    end else if (lw_valid && lw_rd == rs1) begin
      a = lw_val;
    end else begin
      a = rd_a_vld ? rd_a : '0;
    end
    if (rs2 == 5'd0) begin
      b = '0;
    end else if (s2_valid && s2_wr && s2_rd == rs2) begin
      b = s2_val;
    end else if (lw_valid && lw_rd == rs2) begin
      b = lw_val;
    end else begin
      b = rd_b_vld ? rd_b : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: decode and execute
  // ---------------------------------------------------------------------------
  logic [6:0]  opc, f7;
  logic [2:0]  f3;
  logic [4:0]  rd, sh;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
  logic [31:0] ex_next, ex_val, ex_ea, ex_sval;
  logic [1:0]  ex_ssize;
  logic        ex_wr, ex_st, ex_ill, ex_load, take;
  logic        lt_s, lt_u, lti_s, lti_u;

  assign opc   = s1_word[6:0];
  assign rd    = s1_word[11:7];
  assign f3    = s1_word[14:12];
  assign f7    = s1_word[31:25];
  assign sh    = s1_word[24:20];
  assign imm_i = {{20{s1_word[31]}}, s1_word[31:20]};
  assign imm_s = {{20{s1_word[31]}}, s1_word[31:25], s1_word[11:7]};
  assign imm_b = {{19{s1_word[31]}}, s1_word[31], s1_word[7], s1_word[30:25],
                  s1_word[11:8], 1'b0};
  assign imm_u = {s1_word[31:12], 12'h000};
  assign imm_j = {{11{s1_word[31]}}, s1_word[31], s1_word[19:12], s1_word[20],
                  s1_word[30:21], 1'b0};

  assign lt_s  = $signed(a) < $signed(b);
  assign lt_u  = a < b;
  assign lti_s = $signed(a) < $signed(imm_i);
  assign lti_u = a < imm_i;

  always_comb begin
    ex_next  = pc + 32'd4;
    ex_val   = '0;
    ex_ea    = a + imm_i;
    ex_sval  = '0;
    ex_ssize = SizeByte;
    ex_wr    = 1'b0;
    ex_st    = 1'b0;
    ex_ill   = 1'b0;
    ex_load  = 1'b0;
    take     = 1'b0;
    case (opc)
      OpLui: begin
        ex_wr  = 1'b1;
        ex_val = imm_u;
      end
      OpAuipc: begin
        ex_wr  = 1'b1;
        ex_val = pc + imm_u;
      end
      OpJal: begin
        ex_wr   = 1'b1;
        ex_val  = pc + 32'd4;
        ex_next = pc + imm_j;
      end
      OpJalr: begin
        if (f3 != 3'd0) begin
          ex_ill = 1'b1;
        end else begin
          ex_wr   = 1'b1;
          ex_val  = pc + 32'd4;
          ex_next = {ex_ea[31:1], 1'b0};
        end
      end
      OpBranch: begin
        case (f3)
          F3Beq:   take = a == b;
          F3Bne:   take = a != b;
          F3Blt:   take = lt_s;
          F3Bge:   take = !lt_s;
          F3Bltu:  take = lt_u;
          F3Bgeu:  take = !lt_u;
          default: ex_ill = 1'b1;
        endcase
        if (take) begin
          ex_next = pc + imm_b;
        end
      end
      OpLoad: begin
        if (f3 inside {F3Lb, F3Lh, F3Lw, F3Lbu, F3Lhu}) begin
          ex_wr   = 1'b1;
          ex_load = 1'b1;
        end else begin
          ex_ill = 1'b1;
        end
      end
      OpStore: begin
        ex_ea = a + imm_s;
        case (f3)
          3'd0: begin
            ex_st    = 1'b1;
            ex_ssize = SizeByte;
            ex_sval  = {24'h0, b[7:0]};
          end
          3'd1: begin
            ex_st    = 1'b1;
            ex_ssize = SizeHalf;
            ex_sval  = {16'h0, b[15:0]};
          end
          3'd2: begin
            ex_st    = 1'b1;
            ex_ssize = SizeWord;
            ex_sval  = b;
          end
          default: ex_ill = 1'b1;
        endcase
      end
      OpImm: begin
        ex_wr = 1'b1;
        case (f3)
          F3Add:  ex_val = a + imm_i;
          F3Slt:  ex_val = {31'h0, lti_s};
          F3Sltu: ex_val = {31'h0, lti_u};
          F3Xor:  ex_val = a ^ imm_i;
          F3Or:   ex_val = a | imm_i;
          F3And:  ex_val = a & imm_i;
          F3Sll: begin
            if (f7 == F7Zero) ex_val = a << sh;
            else ex_ill = 1'b1;
          end
          default: begin
            if (f7 == F7Zero) ex_val = a >> sh;
            else if (f7 == F7Alt) ex_val = $unsigned($signed(a) >>> sh);
            else ex_ill = 1'b1;
          end
        endcase
      end
      OpReg: begin
        ex_wr = 1'b1;
        if (f7 == F7Zero) begin
          case (f3)
            F3Add:   ex_val = a + b;
            F3Sll:   ex_val = a << b[4:0];
            F3Slt:   ex_val = {31'h0, lt_s};
            F3Sltu:  ex_val = {31'h0, lt_u};
            F3Xor:   ex_val = a ^ b;
            F3Sr:    ex_val = a >> b[4:0];
            F3Or:    ex_val = a | b;
            default: ex_val = a & b;
          endcase
        end else if (f7 == F7Alt && f3 == F3Add) begin
          ex_val = a - b;
        end else if (f7 == F7Alt && f3 == F3Sr) begin
          ex_val = $unsigned($signed(a) >>> b[4:0]);
        end else begin
          ex_ill = 1'b1;
        end
      end
      default: ex_ill = 1'b1;
    endcase
    // Illegal encodings hold the pc and drop every side effect.
    if (ex_ill) begin
      ex_wr    = 1'b0;
      ex_st    = 1'b0;
      ex_load  = 1'b0;
      ex_next  = pc;
      ex_val   = '0;
      ex_sval  = '0;
      ex_ssize = SizeByte;
    end
    if (rd == 5'd0) begin
      ex_wr   = 1'b0;
      ex_load = 1'b0;
    end
    if (!ex_wr) begin
      ex_val = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Data memory: four byte banks; byte k of an access sits in lane (A+k) mod 4.
  // ---------------------------------------------------------------------------
  logic [7:0] dmem [4][ROWS];
  logic [7:0] bank_q [4];
  logic       s1_fire;
  assign s1_fire = advance && s1_valid;

  for (genvar j = 0; j < 4; j++) begin : g_bank
    logic [1:0]    k;
    logic [AW-1:0] baddr;
    logic [RW-1:0] row;
    logic          wen;
    logic [7:0]    wbyte;

    assign k     = 2'(j) - ex_ea[1:0];
    assign baddr = ex_ea[AW-1:0] + AW'(k);
    assign row   = baddr[AW-1:2];
    assign wen   = s1_fire && ex_st && ({1'b0, k} < (3'd1 << ex_ssize));
    assign wbyte = ex_sval[8*k +: 8];

    always_ff @(posedge clk) begin
      if (wen) begin
        dmem[j][row] <= wbyte;
      end
      if (advance) begin
        bank_q[j] <= dmem[j][row];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      pc       <= start_pc;
    end else if (advance) begin
      s1_valid <= in_ch.valid;
      s2_valid <= s1_valid;
      if (s1_valid) begin
        pc <= ex_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_word  <= in_ch.instruction_word;
      s2_pc    <= pc;
      s2_next  <= ex_next;
      s2_wr    <= ex_wr;
      s2_rd    <= ex_wr ? rd : 5'd0;
      s2_alu   <= ex_val;
      s2_load  <= ex_load;
      s2_f3    <= f3;
      s2_lane  <= ex_ea[1:0];
      s2_st    <= ex_st;
      s2_saddr <= ex_st ? ex_ea : '0;
      s2_sval  <= ex_sval;
      s2_ssize <= ex_ssize;
      s2_ill   <= ex_ill;
    end
  end

  // Stage 2: gather load bytes in address order and extend.
  logic [31:0] ld_raw;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ld_raw[8*k +: 8] = bank_q[2'(s2_lane + 2'(k))];
    end
    s2_val = s2_alu;
    if (s2_load) begin
      case (s2_f3)
        F3Lb:    s2_val = {{24{ld_raw[7]}}, ld_raw[7:0]};
        F3Lh:    s2_val = {{16{ld_raw[15]}}, ld_raw[15:0]};
        F3Lbu:   s2_val = {24'h0, ld_raw[7:0]};
        F3Lhu:   s2_val = {16'h0, ld_raw[15:0]};
        default: s2_val = ld_raw;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.instruction_address <= s2_pc;
      out_ch.next_pc             <= s2_next;
      out_ch.writes_register     <= s2_wr;
      out_ch.dest_register       <= s2_rd;
      out_ch.dest_value          <= s2_val;
      out_ch.did_store           <= s2_st;
      out_ch.store_address       <= s2_saddr;
      out_ch.store_value         <= s2_sval;
      out_ch.store_size          <= s2_ssize;
      out_ch.illegal             <= s2_ill;
    end
  end

endmodule
